/* src/swre_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window rank error block.
// Used by every module of the block; it has no dependencies of its own.
package swre_pkg;

   localparam int unsigned WINDOW  = 256;
   localparam int unsigned STAMP_W = 63;
   localparam int unsigned VTIME_W = 32;
   localparam int unsigned RANK_W  = 8;
   localparam int unsigned TOTAL_W = 32;
   localparam int unsigned CNT_W   = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int unsigned STEP_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int unsigned FILL_W  = $clog2(WINDOW + 1);

   localparam logic              REQ_RECORD = 1'b0;
   localparam logic              REQ_FINISH = 1'b1;
   localparam logic [RANK_W-1:0] RANK_MAX   = {RANK_W{1'b1}};

   typedef struct packed {
      logic                       req_type;
      logic [STAMP_W-1:0]         stamp;
      logic signed [VTIME_W-1:0]  vtime;
   } req_beat_type;

   typedef struct packed {
      logic [RANK_W-1:0]          rank_count;
      logic [TOTAL_W-1:0]         total_rank;
      logic [TOTAL_W-1:0]         records_seen;
      logic [RANK_W-1:0]          worst_rank;
      logic [STAMP_W-1:0]         worst_stamp;
      logic signed [VTIME_W-1:0]  worst_vtime;
      logic                       finished;
   } rsp_beat_type;

   typedef struct packed {
      logic [STAMP_W-1:0]         stamp;
      logic signed [VTIME_W-1:0]  vtime;
   } entry_type;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_ROTATE,
      CHAIN_INSERT
   } chain_op_type;

   typedef struct packed {
      chain_op_type op;
      entry_type    entry;
   } chain_ctl_type;

endpackage

/* src/swre_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds a single log entry and passes it on when the ring moves.
// Depends on swre_pkg.
module swre_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  swre_pkg::entry_type d,
   output swre_pkg::entry_type q
);

   swre_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;

endmodule

/* src/swre_chain.sv */
`timescale 1ns / 1ps
// Ring of window cells, newest entry in the first cell and oldest in the last.
// Depends on swre_pkg and swre_cell.
module swre_chain (
   input  logic                    clock,
   input  swre_pkg::chain_ctl_type ctl,
   output swre_pkg::entry_type     head
);

   swre_pkg::entry_type cell_q [swre_pkg::WINDOW];
   swre_pkg::entry_type first_d;
   logic                shift_en;

   assign shift_en = (ctl.op != swre_pkg::CHAIN_HOLD);
   assign first_d  = (ctl.op == swre_pkg::CHAIN_INSERT) ? ctl.entry
                                                        : cell_q[swre_pkg::WINDOW-1];

   swre_cell u_cell_first (
      .clock    (clock),
      .shift_en (shift_en),
      .d        (first_d),
      .q        (cell_q[0])
   );

   for (genvar i = 1; i < swre_pkg::WINDOW; i++) begin : g_cell
      swre_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d        (cell_q[i-1]),
         .q        (cell_q[i])
      );
   end

   assign head = cell_q[swre_pkg::WINDOW-1];

endmodule

/* src/sliding_window_rank_error.sv */
`timescale 1ns / 1ps
// Channel | direction | payload                  | beat taken when
// req     | in        | swre_pkg::req_beat_type  | req_valid high, req_stall low
// rsp     | out       | swre_pkg::rsp_beat_type  | rsp_valid high, rsp_stall low
//
// A record that lands while the window is still filling is inserted and gives no result.
// Any other beat rotates the whole ring of WINDOW cells past one comparator in ST_SCAN,
// then ST_EVAL and ST_EMIT register its result; an end of log on a part-filled window goes
// straight to ST_EMIT. A result waiting under rsp_stall holds the next result in ST_EMIT.
// Reset is synchronous and clears the fill level, totals and worst entry; no clearing pass.
// Depends on swre_pkg and swre_chain.
module sliding_window_rank_error (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  swre_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swre_pkg::rsp_beat_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_EMIT
   } state_type;

   state_type                             state_ff;
   logic [swre_pkg::FILL_W-1:0]           fill_ff;
   logic [swre_pkg::STEP_W-1:0]           step_ff;
   logic [swre_pkg::CNT_W-1:0]            cnt_ff;
   logic                                  fin_ff;
   logic signed [swre_pkg::VTIME_W-1:0]   key_vtime_ff;
   logic [swre_pkg::STAMP_W-1:0]          key_stamp_ff;
   swre_pkg::entry_type                   new_ff;
   logic [swre_pkg::RANK_W-1:0]           rank_ff;
   logic [swre_pkg::TOTAL_W-1:0]          sum_ff;
   logic [swre_pkg::TOTAL_W-1:0]          records_ff;
   logic [swre_pkg::RANK_W-1:0]           best_rank_ff;
   logic [swre_pkg::STAMP_W-1:0]          best_stamp_ff;
   logic signed [swre_pkg::VTIME_W-1:0]   best_vtime_ff;
   logic                                  rsp_valid_ff;
   swre_pkg::rsp_beat_type                rsp_data_ff;

   swre_pkg::chain_ctl_type               chain_ctl;
   swre_pkg::entry_type                   head;
   swre_pkg::entry_type                   req_entry;
   logic                                  req_accept;
   logic                                  full;
   logic                                  less;
   logic [swre_pkg::CNT_W+swre_pkg::RANK_W-1:0] cnt_wide;
   logic [swre_pkg::RANK_W-1:0]           rank_in;
   logic [swre_pkg::TOTAL_W:0]            sum_wide;
   logic [swre_pkg::TOTAL_W-1:0]          sum_in;
   logic [swre_pkg::TOTAL_W-1:0]          records_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign full       = (fill_ff == swre_pkg::FILL_W'(swre_pkg::WINDOW));
   assign req_entry  = '{stamp: req_data.stamp, vtime: req_data.vtime};
   assign less       = ($signed(head.vtime) < $signed(key_vtime_ff));

   assign cnt_wide = (swre_pkg::CNT_W+swre_pkg::RANK_W)'(cnt_ff);
   assign rank_in  = (cnt_wide > (swre_pkg::CNT_W+swre_pkg::RANK_W)'(swre_pkg::RANK_MAX))
                     ? swre_pkg::RANK_MAX : cnt_wide[swre_pkg::RANK_W-1:0];
   assign sum_wide = {1'b0, sum_ff} + (swre_pkg::TOTAL_W+1)'(rank_in);
   assign sum_in   = sum_wide[swre_pkg::TOTAL_W] ? {swre_pkg::TOTAL_W{1'b1}}
                                                 : sum_wide[swre_pkg::TOTAL_W-1:0];
   assign records_in = (&records_ff) ? records_ff
                                     : records_ff + swre_pkg::TOTAL_W'(1);

   always_comb begin
      chain_ctl.op    = swre_pkg::CHAIN_HOLD;
      chain_ctl.entry = new_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.req_type == swre_pkg::REQ_RECORD && !full) begin
               chain_ctl.op    = swre_pkg::CHAIN_INSERT;
               chain_ctl.entry = req_entry;
            end
         end
         ST_SCAN: begin
            chain_ctl.op = swre_pkg::CHAIN_ROTATE;
         end
         ST_EVAL: begin
            if (!fin_ff) begin
               chain_ctl.op = swre_pkg::CHAIN_INSERT;
            end
         end
         default: begin
            chain_ctl.op = swre_pkg::CHAIN_HOLD;
         end
      endcase
   end

   swre_chain u_chain (
      .clock (clock),
      .ctl   (chain_ctl),
      .head  (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         sum_ff        <= '0;
         records_ff    <= '0;
         best_rank_ff  <= '0;
         best_stamp_ff <= '0;
         best_vtime_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  fin_ff       <= (req_data.req_type == swre_pkg::REQ_FINISH);
                  new_ff       <= req_entry;
                  key_vtime_ff <= head.vtime;
                  key_stamp_ff <= head.stamp;
                  cnt_ff       <= '0;
                  step_ff      <= '0;
                  if (full) begin
                     state_ff <= ST_SCAN;
                  end else if (req_data.req_type == swre_pkg::REQ_FINISH) begin
                     rank_ff  <= '0;
                     state_ff <= ST_EMIT;
                  end else begin
                     fill_ff <= fill_ff + swre_pkg::FILL_W'(1);
                  end
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + swre_pkg::CNT_W'(less);
               if (step_ff == swre_pkg::STEP_W'(swre_pkg::WINDOW - 1)) begin
                  state_ff <= ST_EVAL;
               end else begin
                  step_ff <= step_ff + swre_pkg::STEP_W'(1);
               end
            end
            ST_EVAL: begin
               rank_ff <= rank_in;
               sum_ff  <= sum_in;
               if (rank_in > best_rank_ff) begin
                  best_rank_ff  <= rank_in;
                  best_stamp_ff <= key_stamp_ff;
                  best_vtime_ff <= key_vtime_ff;
               end
               if (!fin_ff) begin
                  records_ff <= records_in;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.rank_count   <= rank_ff;
                  rsp_data_ff.total_rank   <= sum_ff;
                  rsp_data_ff.records_seen <= records_ff;
                  rsp_data_ff.worst_rank   <= best_rank_ff;
                  rsp_data_ff.worst_stamp  <= best_stamp_ff;
                  rsp_data_ff.worst_vtime  <= best_vtime_ff;
                  rsp_data_ff.finished     <= fin_ff;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/swre_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the sliding-window rank error block, bound to its top level.
// Depends on swre_pkg and sliding_window_rank_error.
module swre_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input swre_pkg::req_beat_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input swre_pkg::rsp_beat_type rsp_data
);

   // A stalled result beat must stay put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // An end-of-log beat always starts work that blocks the next request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type == swre_pkg::REQ_FINISH |=> req_stall)
      else $error("end-of-log beat did not hold off the request channel");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.worst_rank >= rsp_data.rank_count)
      else $error("worst rank below the reported rank");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rank_count != '0 |-> rsp_data.total_rank != '0)
      else $error("running total missed a non-zero rank");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.worst_rank == '0
      |-> rsp_data.worst_stamp == '0 && rsp_data.worst_vtime == '0)
      else $error("worst entry set without a non-zero rank");

endmodule

bind sliding_window_rank_error swre_checker u_swre_checker (.*);

/* tb/sv/rank_error_checker.sv */
`timescale 1ns / 1ps
// Checker for the sliding-window rank error block: it watches both channels, predicts every
// result from the accepted input beats and compares each one field by field.
// Depends on swre_pkg only.
module rank_error_checker
   import swre_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_beat_type rsp_data,
   output int unsigned  failures,
   output int unsigned  outstanding
);

   logic signed [VTIME_W-1:0] ring_vtime [WINDOW];
   logic [STAMP_W-1:0]        ring_stamp [WINDOW];
   int unsigned               filled;
   int unsigned               oldest;
   logic [TOTAL_W-1:0]        rank_total;
   logic [TOTAL_W-1:0]        post_fill_records;
   logic [RANK_W-1:0]         top_rank;
   logic [STAMP_W-1:0]        top_stamp;
   logic signed [VTIME_W-1:0] top_vtime;
   rsp_beat_type              expected_ranks [$];

   function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   endfunction

   task automatic rank_oldest_entry(output logic [RANK_W-1:0] rank);
      int unsigned smaller;
      smaller = 0;
      for (int i = 0; i < WINDOW; i++) begin
         if (i != oldest && ring_vtime[i] < ring_vtime[oldest])
            smaller++;
      end
      rank = (smaller > RANK_MAX) ? RANK_MAX : smaller[RANK_W-1:0];
      rank_total = add_sat(rank_total, TOTAL_W'(rank));
      if (rank > top_rank) begin
         top_rank  = rank;
         top_stamp = ring_stamp[oldest];
         top_vtime = ring_vtime[oldest];
      end
   endtask

   task automatic predict_rank_result(input req_beat_type beat);
      rsp_beat_type      want;
      logic [RANK_W-1:0] rank;
      logic              produces;
      rank     = '0;
      produces = 1'b1;
      if (beat.req_type == REQ_FINISH) begin
         if (filled >= WINDOW)
            rank_oldest_entry(rank);
      end else if (filled < WINDOW) begin
         ring_vtime[filled] = beat.vtime;
         ring_stamp[filled] = beat.stamp;
         filled++;
         produces = 1'b0;
      end else begin
         rank_oldest_entry(rank);
         ring_vtime[oldest] = beat.vtime;
         ring_stamp[oldest] = beat.stamp;
         oldest = (oldest + 1) % WINDOW;
         post_fill_records = add_sat(post_fill_records, TOTAL_W'(1));
      end
      if (produces) begin
         want.rank_count   = rank;
         want.total_rank   = rank_total;
         want.records_seen = post_fill_records;
         want.worst_rank   = top_rank;
         want.worst_stamp  = top_stamp;
         want.worst_vtime  = top_vtime;
         want.finished     = (beat.req_type == REQ_FINISH);
         expected_ranks.push_back(want);
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         failures          = 0;
         filled            = 0;
         oldest            = 0;
         rank_total        = '0;
         post_fill_records = '0;
         top_rank          = '0;
         top_stamp         = '0;
         top_vtime         = '0;
         expected_ranks.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_rank_result(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_ranks.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result beat with no expectation waiting: rank %0d total %0d",
                           $time, rsp_data.rank_count, rsp_data.total_rank);
               failures++;
            end else begin
               want = expected_ranks.pop_front();
               if (rsp_data.rank_count !== want.rank_count ||
                   rsp_data.total_rank !== want.total_rank ||
                   rsp_data.records_seen !== want.records_seen ||
                   rsp_data.worst_rank !== want.worst_rank ||
                   rsp_data.worst_stamp !== want.worst_stamp ||
                   rsp_data.worst_vtime !== want.worst_vtime ||
                   rsp_data.finished !== want.finished) begin
                  if (failures < 10) begin
                     $display("%0t: result mismatch", $time);
                     $display("   expected rank %0d total %0d seen %0d worst %0d %h %0d fin %b",
                              want.rank_count, want.total_rank, want.records_seen,
                              want.worst_rank, want.worst_stamp, want.worst_vtime,
                              want.finished);
                     $display("   actual   rank %0d total %0d seen %0d worst %0d %h %0d fin %b",
                              rsp_data.rank_count, rsp_data.total_rank, rsp_data.records_seen,
                              rsp_data.worst_rank, rsp_data.worst_stamp, rsp_data.worst_vtime,
                              rsp_data.finished);
                  end
                  failures++;
               end
            end
         end
      end
      outstanding = expected_ranks.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the sliding-window rank error testbench: clock, reset, request beats in bursts,
// a stalling result receiver and the verdict.
// Depends on swre_pkg, sliding_window_rank_error and rank_error_checker.
module tb;
   import swre_pkg::*;

   localparam int unsigned RANDOM_BEATS    = 1180;
   localparam int unsigned EVAL_CYCLES     = WINDOW + 3;
   localparam int unsigned HOLD_OFF_CYCLES = 4 * EVAL_CYCLES;
   localparam longint unsigned CYCLE_LIMIT =
      3 * longint'(RANDOM_BEATS + WINDOW + 40) * longint'(EVAL_CYCLES + 400);
   localparam logic signed [VTIME_W-1:0] VTIME_MAX = {1'b0, {(VTIME_W-1){1'b1}}};
   localparam logic signed [VTIME_W-1:0] VTIME_MIN = {1'b1, {(VTIME_W-1){1'b0}}};
   localparam logic [STAMP_W-1:0]        STAMP_ONES = {STAMP_W{1'b1}};

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_SQUARE
   } stall_mode_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_beat_type    req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_beat_type    rsp_data;
   int unsigned     failures;
   int unsigned     outstanding;
   int unsigned     burst_left;
   longint unsigned cycles = 0;

   sliding_window_rank_error uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rank_error_checker rank_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic offer(input logic kind, input logic [STAMP_W-1:0] stamp,
                        input logic signed [VTIME_W-1:0] vtime);
      req_beat_type beat;
      int unsigned  gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, EVAL_CYCLES + 40)
                                           : $urandom_range(1, 6);
         req_valid <= 1'b0;
         req_data  <= {$urandom, $urandom, $urandom};
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      beat.req_type = kind;
      beat.stamp    = stamp;
      beat.vtime    = vtime;
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      logic                      kind;
      logic [STAMP_W-1:0]        stamp;
      logic signed [VTIME_W-1:0] vtime;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      offer(REQ_FINISH, '0, '0);
      offer(REQ_RECORD, STAMP_ONES, VTIME_MIN);
      offer(REQ_RECORD, '0, VTIME_MAX);
      offer(REQ_RECORD, STAMP_W'({(STAMP_W+1)/2{2'b01}}), '0);
      offer(REQ_RECORD, STAMP_W'({(STAMP_W+1)/2{2'b10}}), -1);
      offer(REQ_RECORD, STAMP_W'(1), 1);
      offer(REQ_FINISH, STAMP_ONES, VTIME_MAX);
      for (int i = 5; i < WINDOW; i++)
         offer(REQ_RECORD, STAMP_W'({$urandom, $urandom}), $signed($urandom_range(0, 8)) - 4);
      offer(REQ_FINISH, '0, '0);
      offer(REQ_FINISH, '0, '0);
      offer(REQ_RECORD, STAMP_ONES, VTIME_MAX);
      offer(REQ_RECORD, '0, VTIME_MIN);
      offer(REQ_FINISH, STAMP_ONES, VTIME_MIN);
      offer(REQ_FINISH, '0, VTIME_MAX);
      offer(REQ_RECORD, STAMP_W'(2), 0);
      offer(REQ_RECORD, STAMP_ONES - 1, VTIME_MAX);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         kind = ($urandom_range(0, 19) == 0) ? REQ_FINISH : REQ_RECORD;
         case ($urandom_range(0, 9))
            0: vtime = $urandom_range(0, 1) ? VTIME_MAX : VTIME_MIN;
            1, 2, 3: vtime = $signed($urandom_range(0, 8)) - 4;
            default: vtime = $urandom;
         endcase
         if ($urandom_range(0, 15) == 0)
            stamp = $urandom_range(0, 1) ? STAMP_ONES : '0;
         else
            stamp = STAMP_W'({$urandom, $urandom});
         offer(kind, stamp, vtime);
         if (kind == REQ_FINISH && $urandom_range(0, 2) == 0)
            offer(REQ_FINISH, stamp, vtime);
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (EVAL_CYCLES + 8) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // The receiver changes its stall pattern from stretch to stretch and, once, holds off
   // long enough for the block to back up and stall its request channel.
   initial begin
      stall_mode_type mode;
      int unsigned    span;
      int unsigned    period;
      longint unsigned hold_at;
      logic           held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      hold_at   = $urandom_range(20000, 60000);
      forever begin
         mode   = stall_mode_type'($urandom_range(0, 3));
         span   = $urandom_range(16, 600);
         period = $urandom_range(1, 12);
         for (int c = 0; c < span; c++) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((c / period) % 2 == 1);
            endcase
         end
         if (!held && cycles >= hold_at) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held = 1'b1;
         end
      end
   end

endmodule

/* sliding_window_rank_error.f */
src/swre_pkg.sv
src/swre_cell.sv
src/swre_chain.sv
src/sliding_window_rank_error.sv
src/swre_checker.sv
tb/sv/rank_error_checker.sv
tb/sv/tb.sv
